FILE: rtl/cardinality_violation_tracker_core_defines.svh
// assertion macros for the cardinality violation tracker
`ifndef CARDINALITY_VIOLATION_TRACKER_CORE_DEFINES_SVH
`define CARDINALITY_VIOLATION_TRACKER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// checked while out of reset
`define CVT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define CVT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CVT_ASSERT(lbl, prop, msg)
`define CVT_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: rtl/cvt_pkg.sv
// shared types and constants of the cardinality violation tracker
package cvt_pkg;

    localparam int DATA_W    = 32;
    localparam int VAR_IDX_W = 10;
    localparam int BOUND_W   = 11;
    localparam int SPAN_W    = 8;
    localparam int CFG_IDX_W = 2;
    localparam int VIOL_W    = 19;
    localparam int SHORT_W   = 19;
    localparam int EXCESS_W  = 11;

    localparam logic REQ_BOUNDS = 1'b0;
    localparam logic REQ_ASSIGN = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CLOSED_MODE,
        REG_VALUE_BASE,
        REG_VALUE_SPAN
    } cvt_reg_t;

    typedef struct packed {
        logic                        req_type;
        logic [VAR_IDX_W-1:0]        var_index;
        logic signed [DATA_W-1:0]    value;
        logic [BOUND_W-1:0]          lower_bound;
        logic [BOUND_W-1:0]          upper_bound;
    } cvt_in_t;

    typedef struct packed {
        logic [VIOL_W-1:0]   violation;
        logic [SHORT_W-1:0]  shortage;
        logic [EXCESS_W-1:0] excess;
        logic                status;
    } cvt_out_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_REBOUND,
        OP_INC,
        OP_DEC
    } cvt_op_t;

    typedef struct packed {
        cvt_op_t op;
        logic    restricted;
    } cvt_alu_ctrl_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MAP,
        ST_BRD,
        ST_BUPD,
        ST_VRD,
        ST_REM_RD,
        ST_REM_UPD,
        ST_ADD_RD,
        ST_ADD_UPD,
        ST_FIN
    } cvt_state_t;

endpackage

FILE: rtl/cardinality_violation_tracker_core.sv
// top level of the cardinality violation tracker: sequencer, tables and totals
//
// Tracks how often each value occurs over a bank of variables against per-value
// lower and upper occurrence bounds, and keeps the total shortage and total
// excess. An item is taken when start is high and busy is low; exactly one
// result comes back per item unless a configuration write aborts it, shown for
// one cycle with done high. The receiver cannot stall: the result must be taken
// in that cycle. A bound write maps its value, then reads and rewrites the slot;
// a rejected bound write or an out-of-range variable index finishes after the
// mapping. An assign reads the variable entry and finishes without touching the
// slot table if the value is unchanged. Every count change is a slot table read
// followed by a write through the one shared update unit; a first assign does
// one, adding to the new value, and a move does two, removal before addition.
// After reset, and after every configuration write, the block sweeps both of
// its tables clear with busy high; the configuration channel stays open
// throughout and a write restarts the sweep.
// Any write to a known register index clears all bounds, counts, variable
// assignments and both totals.
`include "cardinality_violation_tracker_core_defines.svh"

module cardinality_violation_tracker_core #(
    parameter int VALUE_SLOTS   = 256,
    parameter int NUM_VARIABLES = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  cvt_pkg::cvt_in_t                  item,
    output logic                              done,
    output cvt_pkg::cvt_out_t                 result,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cvt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cvt_pkg::DATA_W-1:0]        cfg_data
);

    // table and counter geometry
    localparam int SLOT_W  = $clog2(VALUE_SLOTS);
    localparam int VAR_AW  = $clog2(NUM_VARIABLES);
    localparam int CNT_W   = $clog2(NUM_VARIABLES + 1);
    localparam int BOUND_MAX = (2 ** cvt_pkg::BOUND_W) - 1;
    localparam int SH_W    = $clog2(VALUE_SLOTS * BOUND_MAX + 1);
    localparam int EX_W    = CNT_W;
    localparam int MAX_W   = (SH_W > EX_W) ? SH_W : EX_W;
    localparam int CLR_LEN = (NUM_VARIABLES > VALUE_SLOTS) ? NUM_VARIABLES : VALUE_SLOTS;
    localparam int CLR_W   = $clog2(CLR_LEN);
    localparam logic [cvt_pkg::DATA_W-1:0] SPAN_LIM  = cvt_pkg::DATA_W'(VALUE_SLOTS - 2);
    localparam logic [cvt_pkg::DATA_W-1:0] VAR_LIM   = cvt_pkg::DATA_W'(NUM_VARIABLES);
    localparam logic [cvt_pkg::DATA_W-1:0] SLOT_LIM  = cvt_pkg::DATA_W'(VALUE_SLOTS);
    localparam logic [CLR_W-1:0]           CLR_LAST  = CLR_W'(CLR_LEN - 1);

    // one slot table entry: listed flag, bounds and occurrence count
    typedef struct packed {
        logic                           listed;
        logic [cvt_pkg::BOUND_W-1:0]    lower;
        logic [cvt_pkg::BOUND_W-1:0]    upper;
        logic [CNT_W-1:0]               count;
    } slot_ent_t;

    // one variable entry: assigned flag and current value
    typedef struct packed {
        logic                           valid;
        logic [cvt_pkg::DATA_W-1:0]     value;
    } var_ent_t;

    // sequencer and control state
    cvt_pkg::cvt_state_t state_reg;
    cvt_pkg::cvt_state_t state_next;
    logic [CLR_W-1:0]    clr_cnt_reg;
    logic                done_reg;

    // configuration
    logic                              closed_reg;
    logic signed [cvt_pkg::DATA_W-1:0] base_reg;
    logic [cvt_pkg::SPAN_W-1:0]        span_reg;
    logic [cvt_pkg::SPAN_W-1:0]        span_eff;
    logic                              cfg_hit;

    // totals
    logic [SH_W-1:0] shortage_reg;
    logic [EX_W-1:0] excess_reg;

    // item and datapath registers
    cvt_pkg::cvt_in_t  item_reg;
    cvt_pkg::cvt_out_t result_reg;
    logic [SLOT_W-1:0] new_slot_reg;
    logic [SLOT_W-1:0] old_slot_reg;
    logic              status_reg;

    // memories
    slot_ent_t slot_mem [VALUE_SLOTS];
    var_ent_t  var_mem  [NUM_VARIABLES];
    slot_ent_t slot_rd;
    var_ent_t  var_rd;

    // control from the sequencer
    logic clr_active;
    logic ld_new;
    logic ld_old;
    logic map_old;
    logic rd_old;
    logic slot_upd;
    logic var_upd;
    logic fin;
    cvt_pkg::cvt_alu_ctrl_t alu_ctrl;

    // shared mapping unit
    logic signed [cvt_pkg::DATA_W-1:0] map_value;
    logic [SLOT_W-1:0]                 map_slot;
    logic                              map_covered;

    // shared update unit outputs
    logic [CNT_W-1:0] alu_count;
    logic [SH_W-1:0]  alu_shortage;
    logic [EX_W-1:0]  alu_excess;

    // memory port signals
    logic [SLOT_W-1:0] slot_rd_addr;
    logic [SLOT_W-1:0] slot_wr_addr;
    logic              slot_we;
    slot_ent_t         slot_wr_data;
    logic [VAR_AW-1:0] var_addr;
    logic [VAR_AW-1:0] var_wr_addr;
    logic              var_we;
    var_ent_t          var_wr_data;

    // item decode
    logic accept;
    logic idx_ok;
    logic bound_reject;
    logic same_value;
    logic [MAX_W-1:0] sh_wide;
    logic [MAX_W-1:0] ex_wide;

    assign accept    = start && !busy;
    assign busy      = (state_reg != cvt_pkg::ST_IDLE);
    assign done      = done_reg;
    assign result    = result_reg;
    assign cfg_ready = 1'b1;
    assign cfg_hit   = cfg_valid && cfg_ready
                       && ((cfg_index == cvt_pkg::REG_CLOSED_MODE)
                           || (cfg_index == cvt_pkg::REG_VALUE_BASE)
                           || (cfg_index == cvt_pkg::REG_VALUE_SPAN));

    // span of zero acts as one, span beyond the table is clipped
    always_comb
    begin
        span_eff = (span_reg == '0) ? cvt_pkg::SPAN_W'(1) : span_reg;
        if (cvt_pkg::DATA_W'(span_eff) > SPAN_LIM)
        begin
            span_eff = cvt_pkg::SPAN_W'(SPAN_LIM);
        end
    end

    assign idx_ok       = cvt_pkg::DATA_W'(item_reg.var_index) < VAR_LIM;
    assign bound_reject = !map_covered || (item_reg.lower_bound > item_reg.upper_bound);
    assign same_value   = (var_rd.value == item_reg.value);
    assign var_addr     = VAR_AW'(item_reg.var_index);

    // mapping unit serves the new value first, then the old one on a move
    assign map_value = map_old ? signed'(var_rd.value) : item_reg.value;

    cvt_slot_map #(
        .SLOT_W (SLOT_W)
    ) u_slot_map (
        .value   (map_value),
        .base    (base_reg),
        .span    (span_eff),
        .slot    (map_slot),
        .covered (map_covered)
    );

    cvt_total_alu #(
        .CNT_W (CNT_W),
        .SH_W  (SH_W),
        .EX_W  (EX_W)
    ) u_total_alu (
        .ctrl          (alu_ctrl),
        .count         (slot_rd.count),
        .lower         (slot_rd.lower),
        .upper         (slot_rd.upper),
        .new_lower     (item_reg.lower_bound),
        .new_upper     (item_reg.upper_bound),
        .shortage      (shortage_reg),
        .excess        (excess_reg),
        .count_next    (alu_count),
        .shortage_next (alu_shortage),
        .excess_next   (alu_excess)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cvt_pkg::ST_CLEAR:
            begin
                if (clr_cnt_reg == CLR_LAST)
                begin
                    state_next = cvt_pkg::ST_IDLE;
                end
            end
            cvt_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = cvt_pkg::ST_MAP;
                end
            end
            cvt_pkg::ST_MAP:
            begin
                if (item_reg.req_type == cvt_pkg::REQ_ASSIGN)
                begin
                    state_next = idx_ok ? cvt_pkg::ST_VRD : cvt_pkg::ST_FIN;
                end
                else
                begin
                    state_next = bound_reject ? cvt_pkg::ST_FIN : cvt_pkg::ST_BRD;
                end
            end
            cvt_pkg::ST_BRD:     state_next = cvt_pkg::ST_BUPD;
            cvt_pkg::ST_BUPD:    state_next = cvt_pkg::ST_FIN;
            cvt_pkg::ST_VRD:
            begin
                if (!var_rd.valid)
                begin
                    state_next = cvt_pkg::ST_ADD_RD;
                end
                else if (same_value)
                begin
                    state_next = cvt_pkg::ST_FIN;
                end
                else
                begin
                    state_next = cvt_pkg::ST_REM_RD;
                end
            end
            cvt_pkg::ST_REM_RD:  state_next = cvt_pkg::ST_REM_UPD;
            cvt_pkg::ST_REM_UPD: state_next = cvt_pkg::ST_ADD_RD;
            cvt_pkg::ST_ADD_RD:  state_next = cvt_pkg::ST_ADD_UPD;
            cvt_pkg::ST_ADD_UPD: state_next = cvt_pkg::ST_FIN;
            cvt_pkg::ST_FIN:     state_next = cvt_pkg::ST_IDLE;
            default:             state_next = cvt_pkg::ST_CLEAR;
        endcase
        // a register write invalidates the slot mapping, so start over
        if (cfg_hit)
        begin
            state_next = cvt_pkg::ST_CLEAR;
        end
    end

    // sequencer outputs
    always_comb
    begin
        clr_active = 1'b0;
        ld_new     = 1'b0;
        ld_old     = 1'b0;
        map_old    = 1'b0;
        rd_old     = 1'b0;
        slot_upd   = 1'b0;
        var_upd    = 1'b0;
        fin        = 1'b0;
        alu_ctrl.op         = cvt_pkg::OP_NONE;
        alu_ctrl.restricted = slot_rd.listed || closed_reg;
        case (state_reg)
            cvt_pkg::ST_CLEAR:
            begin
                clr_active = 1'b1;
            end
            cvt_pkg::ST_MAP:
            begin
                ld_new = 1'b1;
            end
            cvt_pkg::ST_BUPD:
            begin
                slot_upd    = 1'b1;
                alu_ctrl.op = cvt_pkg::OP_REBOUND;
            end
            cvt_pkg::ST_VRD:
            begin
                map_old = 1'b1;
                ld_old  = 1'b1;
                var_upd = !var_rd.valid || !same_value;
            end
            cvt_pkg::ST_REM_RD:
            begin
                rd_old = 1'b1;
            end
            cvt_pkg::ST_REM_UPD:
            begin
                rd_old      = 1'b1;
                slot_upd    = 1'b1;
                alu_ctrl.op = cvt_pkg::OP_DEC;
            end
            cvt_pkg::ST_ADD_UPD:
            begin
                slot_upd    = 1'b1;
                alu_ctrl.op = cvt_pkg::OP_INC;
            end
            cvt_pkg::ST_FIN:
            begin
                fin = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // slot table port: clear sweep or read-modify-write of one slot
    assign slot_rd_addr = rd_old ? old_slot_reg : new_slot_reg;

    always_comb
    begin
        if (clr_active)
        begin
            slot_we      = cvt_pkg::DATA_W'(clr_cnt_reg) < SLOT_LIM;
            slot_wr_addr = clr_cnt_reg[SLOT_W-1:0];
            slot_wr_data = '0;
        end
        else
        begin
            slot_we      = slot_upd;
            slot_wr_addr = slot_rd_addr;
            slot_wr_data.count = alu_count;
            if (alu_ctrl.op == cvt_pkg::OP_REBOUND)
            begin
                slot_wr_data.listed = 1'b1;
                slot_wr_data.lower  = item_reg.lower_bound;
                slot_wr_data.upper  = item_reg.upper_bound;
            end
            else
            begin
                slot_wr_data.listed = slot_rd.listed;
                slot_wr_data.lower  = slot_rd.lower;
                slot_wr_data.upper  = slot_rd.upper;
            end
        end
    end

    // variable table port
    always_comb
    begin
        if (clr_active)
        begin
            var_we      = cvt_pkg::DATA_W'(clr_cnt_reg) < VAR_LIM;
            var_wr_addr = clr_cnt_reg[VAR_AW-1:0];
            var_wr_data = '0;
        end
        else
        begin
            var_we            = var_upd;
            var_wr_addr       = var_addr;
            var_wr_data.valid = 1'b1;
            var_wr_data.value = item_reg.value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[slot_wr_addr] <= slot_wr_data;
        end
        slot_rd <= slot_mem[slot_rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (var_we)
        begin
            var_mem[var_wr_addr] <= var_wr_data;
        end
        var_rd <= var_mem[var_addr];
    end

    // control state, configuration and totals
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= cvt_pkg::ST_CLEAR;
            clr_cnt_reg  <= '0;
            done_reg     <= 1'b0;
            closed_reg   <= 1'b0;
            base_reg     <= '0;
            span_reg     <= cvt_pkg::SPAN_W'(254);
            shortage_reg <= '0;
            excess_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= fin;
            if (cfg_hit)
            begin
                clr_cnt_reg  <= '0;
                shortage_reg <= '0;
                excess_reg   <= '0;
            end
            else
            begin
                if (clr_active)
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                end
                if (slot_upd)
                begin
                    shortage_reg <= alu_shortage;
                    excess_reg   <= alu_excess;
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    cvt_pkg::REG_CLOSED_MODE: closed_reg <= cfg_data[0];
                    cvt_pkg::REG_VALUE_BASE:  base_reg   <= signed'(cfg_data);
                    cvt_pkg::REG_VALUE_SPAN:  span_reg   <= cfg_data[cvt_pkg::SPAN_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // result is the larger total, both totals cut to the port widths
    assign sh_wide = MAX_W'(shortage_reg);
    assign ex_wide = MAX_W'(excess_reg);

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item;
        end
        if (ld_new)
        begin
            new_slot_reg <= map_slot;
            status_reg   <= (item_reg.req_type == cvt_pkg::REQ_BOUNDS) && bound_reject;
        end
        if (ld_old)
        begin
            old_slot_reg <= map_slot;
        end
        if (fin)
        begin
            result_reg.violation <= cvt_pkg::VIOL_W'((sh_wide > ex_wide) ? sh_wide : ex_wide);
            result_reg.shortage  <= cvt_pkg::SHORT_W'(shortage_reg);
            result_reg.excess    <= cvt_pkg::EXCESS_W'(excess_reg);
            result_reg.status    <= status_reg;
        end
    end

    // checks
    `CVT_ASSERT(a_done_single, done |=> !done, "result strobe held longer than one cycle")
    `CVT_ASSERT(a_accept_busy, accept |=> busy, "block not busy after taking an item")
    `CVT_ASSERT(a_status_bounds, done && result.status |-> item_reg.req_type == cvt_pkg::REQ_BOUNDS, "reject status on an assign item")
    `CVT_ASSERT(a_idle_no_write, state_reg == cvt_pkg::ST_IDLE |-> !slot_we && !var_we, "table written while idle")
    `CVT_ASSERT_ALWAYS(a_reset_busy, !rst_n |=> busy, "block not busy after reset")

endmodule

FILE: rtl/cvt_slot_map.sv
// maps a value onto a table slot, edge slots for values outside the span
module cvt_slot_map #(
    parameter int SLOT_W = 8
) (
    input  logic signed [cvt_pkg::DATA_W-1:0] value,
    input  logic signed [cvt_pkg::DATA_W-1:0] base,
    input  logic [cvt_pkg::SPAN_W-1:0]        span,
    output logic [SLOT_W-1:0]                 slot,
    output logic                              covered
);

    logic [cvt_pkg::DATA_W:0]   off;
    logic [cvt_pkg::SPAN_W:0]   slot_wide;
    logic                       below;
    logic                       above;

    always_comb
    begin
        off   = {value[cvt_pkg::DATA_W-1], value} - {base[cvt_pkg::DATA_W-1], base};
        below = off[cvt_pkg::DATA_W];
        above = !below && ((off[cvt_pkg::DATA_W:cvt_pkg::SPAN_W] != '0)
                           || (off[cvt_pkg::SPAN_W-1:0] >= span));
        if (below)
        begin
            slot_wide = '0;
        end
        else if (above)
        begin
            slot_wide = {1'b0, span} + 1'b1;
        end
        else
        begin
            slot_wide = {1'b0, off[cvt_pkg::SPAN_W-1:0]} + 1'b1;
        end
        covered = !below && !above;
        slot    = SLOT_W'(slot_wide);
    end

endmodule

FILE: rtl/cvt_total_alu.sv
// shared update unit: one slot's count and its effect on both totals
module cvt_total_alu #(
    parameter int CNT_W = 11,
    parameter int SH_W  = 20,
    parameter int EX_W  = 11
) (
    input  cvt_pkg::cvt_alu_ctrl_t          ctrl,
    input  logic [CNT_W-1:0]                count,
    input  logic [cvt_pkg::BOUND_W-1:0]     lower,
    input  logic [cvt_pkg::BOUND_W-1:0]     upper,
    input  logic [cvt_pkg::BOUND_W-1:0]     new_lower,
    input  logic [cvt_pkg::BOUND_W-1:0]     new_upper,
    input  logic [SH_W-1:0]                 shortage,
    input  logic [EX_W-1:0]                 excess,
    output logic [CNT_W-1:0]                count_next,
    output logic [SH_W-1:0]                 shortage_next,
    output logic [EX_W-1:0]                 excess_next
);

    localparam int CMP_W = ((CNT_W > cvt_pkg::BOUND_W) ? CNT_W : cvt_pkg::BOUND_W) + 1;

    logic [CMP_W-1:0] c;
    logic [CMP_W-1:0] c_inc;
    logic [CMP_W-1:0] c_dec;
    logic [CMP_W-1:0] lo;
    logic [CMP_W-1:0] up;
    logic [CMP_W-1:0] nlo;
    logic [CMP_W-1:0] nup;
    logic [CMP_W-1:0] sh_old;
    logic [CMP_W-1:0] sh_new;
    logic [CMP_W-1:0] ex_old;
    logic [CMP_W-1:0] ex_new;

    always_comb
    begin
        c     = CMP_W'(count);
        lo    = CMP_W'(lower);
        up    = CMP_W'(upper);
        nlo   = CMP_W'(new_lower);
        nup   = CMP_W'(new_upper);
        c_inc = c + 1'b1;
        c_dec = c - 1'b1;

        // old contribution counts only if the slot was restricted
        sh_old = (ctrl.restricted && (lo > c)) ? lo - c : '0;
        ex_old = (ctrl.restricted && (c > up)) ? c - up : '0;
        sh_new = (nlo > c) ? nlo - c : '0;
        ex_new = (c > nup) ? c - nup : '0;

        count_next    = count;
        shortage_next = shortage;
        excess_next   = excess;

        case (ctrl.op)
            cvt_pkg::OP_REBOUND:
            begin
                shortage_next = shortage - SH_W'(sh_old) + SH_W'(sh_new);
                excess_next   = excess - EX_W'(ex_old) + EX_W'(ex_new);
            end
            cvt_pkg::OP_INC:
            begin
                count_next = CNT_W'(c_inc);
                if (ctrl.restricted)
                begin
                    if (c_inc <= lo)
                    begin
                        shortage_next = shortage - SH_W'(1);
                    end
                    else if (c_inc > up)
                    begin
                        excess_next = excess + EX_W'(1);
                    end
                end
            end
            cvt_pkg::OP_DEC:
            begin
                // a count already at zero stays there
                if (count != '0)
                begin
                    count_next = CNT_W'(c_dec);
                    if (ctrl.restricted)
                    begin
                        if (c_dec < lo)
                        begin
                            shortage_next = shortage + SH_W'(1);
                        end
                        else if (c_dec >= up)
                        begin
                            excess_next = excess - EX_W'(1);
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule
